FILE: rtl/core/sky_pkg.sv
// Shared types and field widths for the skyline atlas allocator.
// No dependencies; imported by sky_ctrl and skyline_atlas_allocator.
package sky_pkg;

    localparam int RECT_W   = 8;   // width of rect_width / rect_height
    localparam int PAGE_W   = 3;   // width of page_index
    localparam int POS_W    = 7;   // width of pos_x / pos_y

    // One placement result as it travels from the sequencer to the output register.
    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] page_index;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } t_sky_res;

endpackage

FILE: rtl/core/sky_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; instantiated by sky_ctrl.
module sky_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sky_ctrl.sv
// Placement sequencer: column fill store, prefix-maximum scratch store and the scan FSM.
// Depends on sky_pkg and sky_ram.
module sky_ctrl import sky_pkg::*; #(
    parameter int PAGES   = 1,
    parameter int COLUMNS = 128,
    parameter int ROWS    = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RECT_W-1:0] i_width,
    input  logic [RECT_W-1:0] i_height,
    output logic              o_idle,
    output logic              o_done,
    input  logic              i_ack,
    output t_sky_res          o_res
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int FW    = $clog2(ROWS + 1);
    localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int MW    = (CW > FW) ? CW : FW;
    localparam int SW    = ((MW > RECT_W) ? MW : RECT_W) + 2;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_P1   = 4'd2;
    localparam logic [3:0] S_P1D  = 4'd3;
    localparam logic [3:0] S_P2   = 4'd4;
    localparam logic [3:0] S_P2D  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [RECT_W-1:0] r_w, r_h, r_cnt, r_wk;
    logic [PGW-1:0]    r_page;
    logic [AW-1:0]     r_base;
    logic [CW-1:0]     r_i;
    logic              r_pv, r_ppass, r_pflag, r_pwin;
    logic [CW-1:0]     r_pidx;
    logic [FW-1:0]     r_prev, r_suf, r_best;
    logic [CW-1:0]     r_bestx;
    logic              r_any;
    t_sky_res          r_res;

    // memory ports
    logic              fill_we;
    logic [AW-1:0]     fill_waddr, fill_raddr;
    logic [FW-1:0]     fill_wdata, fill_rdata;
    logic              pre_we;
    logic [CW-1:0]     pre_waddr, pre_raddr;
    logic [FW-1:0]     pre_wdata, pre_rdata;

    logic [SW-1:0]     win_end, w_ext, top_sum;
    logic              win_ok, too_wide, fits;
    logic [FW-1:0]     pval, sval, top;
    logic              last_i, blk_start, blk_end;
    logic [RECT_W-1:0] w_m1;

    sky_ram #(.DEPTH(DEPTH), .WIDTH(FW)) u_fill (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    sky_ram #(.DEPTH(COLUMNS), .WIDTH(FW)) u_pre (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (pre_waddr),
        .i_wdata (pre_wdata),
        .i_raddr (pre_raddr),
        .o_rdata (pre_rdata)
    );

    assign w_m1      = r_w - RECT_W'(1);
    assign w_ext     = SW'(r_w);
    assign win_end   = SW'(r_i) + w_ext;
    assign win_ok    = (win_end <= SW'(COLUMNS));
    assign too_wide  = (SW'(i_width) > SW'(COLUMNS));
    assign last_i    = (r_i == CW'(COLUMNS - 1));
    assign blk_start = (r_cnt == '0);
    assign blk_end   = last_i || (r_cnt == w_m1);
    assign top_sum   = SW'(r_best) + SW'(r_h);
    assign fits      = r_any && (top_sum <= SW'(ROWS));

    // data returning from the read issued in the previous cycle
    assign pval = (r_pflag || fill_rdata > r_prev) ? fill_rdata : r_prev;
    assign sval = (r_pflag || fill_rdata > r_suf)  ? fill_rdata : r_suf;
    assign top  = (pre_rdata > sval) ? pre_rdata : sval;

    assign fill_raddr = r_base + AW'(r_i);
    assign pre_raddr  = CW'(win_end - SW'(1));

    assign pre_we    = r_pv && !r_ppass;
    assign pre_waddr = r_pidx;
    assign pre_wdata = pval;

    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = r_clr_addr;
        fill_wdata = '0;
        if (r_state == S_CLR) begin
            fill_we = 1'b1;
        end else if (r_state == S_WR) begin
            fill_we    = 1'b1;
            fill_waddr = r_base + AW'(SW'(r_bestx) + SW'(r_wk));
            fill_wdata = FW'(top_sum);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_width == '0 || i_height == '0 || too_wide) n_state = S_DONE;
                    else n_state = S_P1;
                end
            end
            S_P1: begin
                if (last_i) n_state = S_P1D;
            end
            S_P1D: n_state = S_P2;
            S_P2: begin
                if (r_i == '0) n_state = S_P2D;
            end
            S_P2D: n_state = S_CHK;
            S_CHK: begin
                if (fits) n_state = S_WR;
                else if (r_page == PGW'(PAGES - 1)) n_state = S_DONE;
                else n_state = S_P1;
            end
            S_WR: begin
                if (r_wk == w_m1) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ack) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_pv       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_P1) || (r_state == S_P2);
            if (r_state == S_CLR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_pv && !r_ppass) r_prev <= pval;
        if (r_pv && r_ppass) begin
            r_suf <= sval;
            if (r_pwin && (top < r_best || (r_any && top == r_best))) begin
                r_best  <= top;
                r_bestx <= r_pidx;
                r_any   <= 1'b1;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_w    <= i_width;
                r_h    <= i_height;
                r_page <= '0;
                r_base <= '0;
                r_i    <= '0;
                r_cnt  <= '0;
                r_res  <= '0;
            end
            S_P1: begin
                r_ppass <= 1'b0;
                r_pidx  <= r_i;
                r_pflag <= blk_start;
                if (!last_i) begin
                    r_i   <= r_i + CW'(1);
                    r_cnt <= (r_cnt == w_m1) ? '0 : r_cnt + RECT_W'(1);
                end
            end
            S_P1D: begin
                r_i    <= CW'(COLUMNS - 1);
                r_best <= FW'(ROWS);
                r_any  <= 1'b0;
            end
            S_P2: begin
                r_ppass <= 1'b1;
                r_pidx  <= r_i;
                r_pflag <= blk_end;
                r_pwin  <= win_ok;
                r_cnt   <= blk_start ? w_m1 : r_cnt - RECT_W'(1);
                if (r_i != '0) r_i <= r_i - CW'(1);
            end
            S_CHK: begin
                r_wk  <= '0;
                r_i   <= '0;
                r_cnt <= '0;
                if (!fits && r_page != PGW'(PAGES - 1)) begin
                    r_page <= r_page + PGW'(1);
                    r_base <= r_base + AW'(COLUMNS);
                end
            end
            S_WR: begin
                r_wk <= r_wk + RECT_W'(1);
                if (r_wk == w_m1) begin
                    r_res.found      <= 1'b1;
                    r_res.page_index <= PAGE_W'(r_page);
                    r_res.pos_x      <= POS_W'(r_bestx);
                    r_res.pos_y      <= POS_W'(r_best);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

FILE: rtl/core/skyline_atlas_allocator.sv
// Skyline atlas allocator: places rectangles into PAGES atlas pages of COLUMNS x ROWS cells.
// Depends on sky_pkg and sky_ctrl (which holds the column fill memory).
//
// Each page keeps a filled height per column in a synchronous RAM. A request
// tries the pages in order; on a page every start column is scored by the
// highest fill under the rectangle and the leftmost lowest start wins. Window
// maxima come from two sweeps over the page's columns: a left-to-right sweep
// stores block prefix maxima (blocks of rect_width columns) in a scratch RAM,
// and a right-to-left sweep forms block suffix maxima and combines the two.
// The running time is set by the single read port of the fill RAM, which is read
// once per column per sweep, and by writing back one column per cycle. A
// zero-sized or over-wide request returns "not found" without a scan. After
// reset, a clearing pass zeroes the fill RAM one entry per cycle; o_in_stall is
// held high throughout. Items are taken one at a time; a finished result waits in
// the output register while the next item is accepted and processed.
module skyline_atlas_allocator import sky_pkg::*; #(
    parameter int PAGES   = 1,
    parameter int COLUMNS = 128,
    parameter int ROWS    = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [RECT_W-1:0] i_rect_width,
    input  logic [RECT_W-1:0] i_rect_height,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_found,
    output logic [PAGE_W-1:0] o_page_index,
    output logic [POS_W-1:0]  o_pos_x,
    output logic [POS_W-1:0]  o_pos_y
);

    logic     ctrl_idle, ctrl_done, ctrl_ack;
    t_sky_res ctrl_res;
    logic     r_out_valid;
    t_sky_res r_out;

    // Accept a transfer only while the sequencer is idle.
    assign o_in_stall = !ctrl_idle;

    sky_ctrl #(.PAGES(PAGES), .COLUMNS(COLUMNS), .ROWS(ROWS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && ctrl_idle),
        .i_width  (i_rect_width),
        .i_height (i_rect_height),
        .o_idle   (ctrl_idle),
        .o_done   (ctrl_done),
        .i_ack    (ctrl_ack),
        .o_res    (ctrl_res)
    );

    // Load the output register when it is empty or being drained this cycle.
    assign ctrl_ack = ctrl_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled; advance only on a new result.
    always_ff @(posedge i_clk) begin
        if (ctrl_ack) begin
            r_out <= ctrl_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out.found;
    assign o_page_index = r_out.page_index;
    assign o_pos_x      = r_out.pos_x;
    assign o_pos_y      = r_out.pos_y;

endmodule
